[rtl/ipv4p_pkg.sv]
// ----------------------------------------------------------------------------
// ipv4p_pkg
// Shared types and constants for the dotted-quad address parser.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

    // Character codes that the parser looks for.
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Most digits allowed in one field.
    localparam logic [1:0] MAX_DIGITS = 2'd3;

    // Index of the last field, which needs no dot after it.
    localparam logic [1:0] LAST_FIELD = 2'd3;

    localparam int unsigned OCTET_W = 10;
    localparam int unsigned NUM_FIELDS = 4;

    // Parse status, one-hot.
    typedef enum logic [2:0] {
        ST_SCAN = 3'b001,
        ST_DONE = 3'b010,
        ST_ERR  = 3'b100
    } t_status;

    // Everything the parser carries from one character to the next.
    typedef struct packed {
        logic [1:0]                               field_index;
        logic [1:0]                               digit_count;
        logic [NUM_FIELDS-1:0][OCTET_W-1:0]       values;
        t_status                                  status;
    } t_parse_state;

    // One finished parse, as sent to the receiver.
    typedef struct packed {
        logic [NUM_FIELDS-1:0][OCTET_W-1:0]       octets;
        logic                                     well_formed;
    } t_result;

    localparam t_parse_state PARSE_RESET = '{
        field_index: 2'd0,
        digit_count: 2'd0,
        values:      '0,
        status:      ST_SCAN
    };

endpackage

[rtl/ipv4p_step.sv]
// ----------------------------------------------------------------------------
// ipv4p_step
// Next-state and result logic for one character of the address text.
// ----------------------------------------------------------------------------
module ipv4p_step (
    input  ipv4p_pkg::t_parse_state i_state,
    input  logic [7:0]              i_char,
    input  logic                    i_last,
    output ipv4p_pkg::t_parse_state o_state,
    output ipv4p_pkg::t_result      o_result
);

    logic                   is_digit;
    logic [3:0]             digit;
    logic [9:0]             cur_value;
    logic [13:0]            acc_wide;
    ipv4p_pkg::t_parse_state upd;
    ipv4p_pkg::t_status     fin_status;
    logic                   ok;

    // Classify the character and form the extended accumulator value.
    assign is_digit  = i_char inside {[ipv4p_pkg::CHAR_ZERO:ipv4p_pkg::CHAR_NINE]};
    assign digit     = i_char[3:0];
    assign cur_value = i_state.values[i_state.field_index];
    assign acc_wide  = ({4'd0, cur_value} << 3) + ({4'd0, cur_value} << 1)
                     + {10'd0, digit};

    // Apply the character to the scan state.
    always_comb begin
        upd = i_state;
        if (i_state.status == ipv4p_pkg::ST_SCAN) begin
            if (is_digit) begin
                if (i_state.digit_count == ipv4p_pkg::MAX_DIGITS) begin
                    upd.status = ipv4p_pkg::ST_ERR;
                end else begin
                    upd.values[i_state.field_index] = acc_wide[9:0];
                    upd.digit_count = i_state.digit_count + 2'd1;
                end
            end else if (i_state.digit_count == 2'd0) begin
                upd.status = ipv4p_pkg::ST_ERR;
            end else if (i_state.field_index != ipv4p_pkg::LAST_FIELD) begin
                if (i_char == ipv4p_pkg::CHAR_DOT) begin
                    upd.field_index = i_state.field_index + 2'd1;
                    upd.digit_count = 2'd0;
                end else begin
                    upd.status = ipv4p_pkg::ST_ERR;
                end
            end else begin
                upd.status = ipv4p_pkg::ST_DONE;
            end
        end
    end

    // The end of the text terminates the fourth field if it is still open.
    always_comb begin
        fin_status = upd.status;
        if (upd.status == ipv4p_pkg::ST_SCAN) begin
            if (upd.field_index == ipv4p_pkg::LAST_FIELD && upd.digit_count != 2'd0) begin
                fin_status = ipv4p_pkg::ST_DONE;
            end else begin
                fin_status = ipv4p_pkg::ST_ERR;
            end
        end
    end

    assign ok = (fin_status == ipv4p_pkg::ST_DONE);

    // Result fields are forced to zero on a malformed address.
    assign o_result.octets      = ok ? upd.values : '0;
    assign o_result.well_formed = ok;

    // After the final character the parser starts over for the next string.
    assign o_state = i_last ? ipv4p_pkg::PARSE_RESET : upd;

endmodule

[rtl/ipv4_dotted_quad_parser.sv]
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser
// Parses dotted-decimal IPv4 address text, one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_valid / o_ready) carries one ASCII character per
//   transfer, with i_end_of_text set on the final character of a string.
//   The output channel (o_valid / i_ready) carries one result per string:
//   four field values of 0 to 999 and a well-formed flag. A malformed
//   string gives all-zero fields and the flag low.
//   The result is presented in the cycle after the transfer of the
//   final character. One character is taken every cycle while o_ready
//   is high; the parse state is updated by a single level of logic in
//   the accepting cycle. The result sits in an output register. While it
//   is held, o_ready follows i_ready, so the input stalls in every cycle
//   in which a result waits and the receiver is not ready. A result taken
//   in a cycle frees the register for the next one in that same cycle.
//   Reset clears the parse state to the start of a string and empties the
//   output register.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_byte,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [9:0] o_octet_a,
    output logic [9:0] o_octet_b,
    output logic [9:0] o_octet_c,
    output logic [9:0] o_octet_d,
    output logic       o_well_formed
);

    ipv4p_pkg::t_parse_state r_state;
    ipv4p_pkg::t_parse_state n_state;
    ipv4p_pkg::t_result      r_result;
    ipv4p_pkg::t_result      n_result;
    logic                    r_out_valid;
    logic                    in_xfer;
    logic                    out_xfer;

    // Handshake: the output register frees up in the same cycle it drains.
    assign out_xfer = r_out_valid && i_ready;
    assign o_ready  = !r_out_valid || i_ready;
    assign in_xfer  = i_valid && o_ready;

    ipv4p_step u_step (
        .i_state  (r_state),
        .i_char   (i_char_byte),
        .i_last   (i_end_of_text),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Parse state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ipv4p_pkg::PARSE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_state <= n_state;
            end
            if (in_xfer && i_end_of_text) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_end_of_text) begin
            r_result <= n_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_octet_a     = r_result.octets[0];
    assign o_octet_b     = r_result.octets[1];
    assign o_octet_c     = r_result.octets[2];
    assign o_octet_d     = r_result.octets[3];
    assign o_well_formed = r_result.well_formed;

    // The final character of a string always produces a result next cycle.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_end_of_text) |=> o_valid)
        else $error("final character did not produce a result");

    // A malformed result carries only zero fields.
    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_well_formed) |->
        (o_octet_a == 10'd0 && o_octet_b == 10'd0 &&
         o_octet_c == 10'd0 && o_octet_d == 10'd0))
        else $error("malformed result has nonzero fields");

    // Each string starts from a clean parse state.
    a_restart_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_end_of_text) |=>
        (r_state.field_index == 2'd0 && r_state.digit_count == 2'd0 &&
         r_state.status == ipv4p_pkg::ST_SCAN))
        else $error("parse state not cleared after final character");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !o_ready)
        else $error("input accepted while a held result is stalled");

endmodule
